/* hw/rtl/gcr_pkg.sv */
package gcr_pkg;

   localparam int DEF_MAX_SOURCE_WIDTH  = 256;
   localparam int DEF_MAX_SOURCE_HEIGHT = 256;
   localparam int DEF_ANGLE_FRAC_BITS   = 14;
   localparam int DEF_QUEUE_DEPTH       = 4;

   localparam int LUMA_R = 299;
   localparam int LUMA_G = 587;
   localparam int LUMA_B = 114;
   localparam int LUM_W  = 18;

   // floor(lum / 1000) == (lum * GRAY_RECIP) >> GRAY_SHIFT for every lum up to 255000.
   localparam int GRAY_RECIP  = 268436;
   localparam int GRAY_SHIFT  = 28;
   localparam int GRAY_PROD_W = 37;

   localparam int REL_W  = 10;
   localparam int PROD_W = 26;
   localparam int SUM_W  = 27;
   localparam int POS_W  = 28;

   localparam logic [2:0] CSR_COS_ANGLE     = 3'd0;
   localparam logic [2:0] CSR_SIN_ANGLE     = 3'd1;
   localparam logic [2:0] CSR_SOURCE_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_SOURCE_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_DEST_WIDTH    = 3'd4;
   localparam logic [2:0] CSR_DEST_HEIGHT   = 3'd5;

   localparam logic signed [15:0] RST_COS_ANGLE = 16'sd16384;
   localparam logic signed [15:0] RST_SIN_ANGLE = 16'sd0;
   localparam logic [8:0]         RST_SIZE      = 9'd256;

   typedef struct packed {
      logic       func;
      logic       frame_start;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [8:0] dest_x;
      logic [8:0] dest_y;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       inside_source;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic [8:0]         source_width;
      logic [8:0]         source_height;
      logic [8:0]         dest_width;
      logic [8:0]         dest_height;
   } cfg_type;

   typedef struct packed {
      logic                    is_read;
      logic                    frame_start;
      logic [LUM_W-1:0]        lum;
      logic signed [REL_W-1:0] rel_x;
      logic signed [REL_W-1:0] rel_y;
   } work_type;

endpackage

/* hw/rtl/gcr_front.sv */
module gcr_front (
   input  logic              clock,
   input  logic              reset,
   input  gcr_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  gcr_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output gcr_pkg::work_type q_data
);
   import gcr_pkg::*;

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;
   work_type classified;
   logic     accept;

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;
   assign q_data    = data_ff;

   always_comb begin
      classified.is_read     = req_data.func;
      classified.frame_start = req_data.frame_start;
      classified.lum         = LUM_W'(req_data.red) * LUM_W'(LUMA_R)
                             + LUM_W'(req_data.green) * LUM_W'(LUMA_G)
                             + LUM_W'(req_data.blue) * LUM_W'(LUMA_B);
      classified.rel_x       = $signed({1'b0, req_data.dest_x})
                             - $signed({2'b00, cfg.dest_width[8:1]});
      classified.rel_y       = $signed({1'b0, req_data.dest_y})
                             - $signed({2'b00, cfg.dest_height[8:1]});
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = classified;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

/* hw/rtl/gcr_queue.sv */
module gcr_queue #(
   parameter int DEPTH = gcr_pkg::DEF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gcr_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output gcr_pkg::work_type pop_data,
   output logic              empty
);
   import gcr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type          slots [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds its depth");

endmodule

/* hw/rtl/gcr_back.sv */
module gcr_back #(
   parameter int MAX_SOURCE_WIDTH  = gcr_pkg::DEF_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = gcr_pkg::DEF_MAX_SOURCE_HEIGHT,
   parameter int ANGLE_FRAC_BITS   = gcr_pkg::DEF_ANGLE_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  gcr_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  gcr_pkg::work_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gcr_pkg::rsp_type  rsp_data
);
   import gcr_pkg::*;

   localparam int STORE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = 18;
   localparam logic [8:0] SW_CAP = 9'((MAX_SOURCE_WIDTH > 511) ? 511 : MAX_SOURCE_WIDTH);
   localparam logic [8:0] SH_CAP = 9'((MAX_SOURCE_HEIGHT > 511) ? 511 : MAX_SOURCE_HEIGHT);
   localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((1 << ANGLE_FRAC_BITS) - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_MAP  = 3'd2;
   localparam logic [2:0] S_ADDR = 3'd3;
   localparam logic [2:0] S_MEM  = 3'd4;
   localparam logic [2:0] S_PREP = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]                state_ff, state_in;
   work_type                  cur_ff, cur_in;
   logic [GRAY_PROD_W-1:0]    gprod_ff, gprod_in;
   logic signed [PROD_W-1:0]  pcx_ff, pcx_in, psy_ff, psy_in;
   logic signed [PROD_W-1:0]  pcy_ff, pcy_in, psx_ff, psx_in;
   logic [8:0]                sx_ff, sx_in, sy_ff, sy_in;
   logic                      inside_ff, inside_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [7:0]                min_gray_ff, min_gray_in;
   logic [7:0]                max_gray_ff, max_gray_in;
   logic [7:0]                rem_ff, rem_in;
   logic [7:0]                quo_ff, quo_in;
   logic [7:0]                den_ff, den_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic [7:0]                pix_ff, pix_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [7:0]                gray_mem [STORE_DEPTH];
   logic [7:0]                rd_data_ff;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [7:0]                gray;
   logic [7:0]                base_min, base_max;
   logic [8:0]                sw, sh;
   logic signed [SUM_W-1:0]   sum_x, sum_y, bias_x, bias_y, tx, ty;
   logic signed [POS_W-1:0]   px, py;
   logic                      in_x, in_y;
   logic [IDX_W-1:0]          idx_full;
   logic [7:0]                diff;
   logic [15:0]               num;
   logic [8:0]                trial;
   logic                      qbit;

   assign sw        = (cfg.source_width > SW_CAP) ? SW_CAP : cfg.source_width;
   assign sh        = (cfg.source_height > SH_CAP) ? SH_CAP : cfg.source_height;
   assign gray      = gprod_ff[GRAY_SHIFT +: 8];
   assign wr_addr   = cur_ff.frame_start ? '0 : addr_ff;
   assign base_min  = cur_ff.frame_start ? 8'hFF : min_gray_ff;
   assign base_max  = cur_ff.frame_start ? 8'h00 : max_gray_ff;
   assign sum_x     = SUM_W'(pcx_ff) + SUM_W'(psy_ff);
   assign sum_y     = SUM_W'(pcy_ff) - SUM_W'(psx_ff);
   assign bias_x    = sum_x[SUM_W-1] ? sum_x + BIAS : sum_x;
   assign bias_y    = sum_y[SUM_W-1] ? sum_y + BIAS : sum_y;
   assign tx        = bias_x >>> ANGLE_FRAC_BITS;
   assign ty        = bias_y >>> ANGLE_FRAC_BITS;
   assign px        = POS_W'(tx) + $signed(POS_W'(sw[8:1]));
   assign py        = POS_W'(ty) + $signed(POS_W'(sh[8:1]));
   assign in_x      = !px[POS_W-1] && (px < $signed(POS_W'(sw)));
   assign in_y      = !py[POS_W-1] && (py < $signed(POS_W'(sh)));
   assign idx_full  = IDX_W'(sy_ff) * IDX_W'(sw) + IDX_W'(sx_ff);
   assign diff      = rd_data_ff - min_gray_ff;
   assign num       = {diff, 8'h00} - {8'h00, diff};
   assign trial     = {rem_ff, quo_ff[7]};
   assign qbit      = (trial >= {1'b0, den_ff});
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      gprod_in     = gprod_ff;
      pcx_in       = pcx_ff;
      psy_in       = psy_ff;
      pcy_in       = pcy_ff;
      psx_in       = psx_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      inside_in    = inside_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      min_gray_in  = min_gray_ff;
      max_gray_in  = max_gray_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               gprod_in = GRAY_PROD_W'(q_data.lum) * GRAY_PROD_W'(GRAY_RECIP);
               pcx_in   = PROD_W'(cfg.cos_angle) * PROD_W'(q_data.rel_x);
               psy_in   = PROD_W'(cfg.sin_angle) * PROD_W'(q_data.rel_y);
               pcy_in   = PROD_W'(cfg.cos_angle) * PROD_W'(q_data.rel_y);
               psx_in   = PROD_W'(cfg.sin_angle) * PROD_W'(q_data.rel_x);
               state_in = q_data.is_read ? S_MAP : S_LOAD;
            end
         end
         S_LOAD: begin
            wr_en       = 1'b1;
            addr_in     = (wr_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_addr + 1'b1;
            min_gray_in = (gray < base_min) ? gray : base_min;
            max_gray_in = (gray > base_max) ? gray : base_max;
            state_in    = S_IDLE;
         end
         S_MAP: begin
            sx_in     = px[8:0];
            sy_in     = py[8:0];
            inside_in = in_x && in_y;
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            idx_in = ADDR_W'(idx_full);
            pix_in = 8'h00;
            state_in = inside_ff ? S_MEM : S_OUT;
         end
         S_MEM: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            den_in = max_gray_ff - min_gray_ff;
            rem_in = num[15:8];
            quo_in = num[7:0];
            cnt_in = 3'd7;
            if (max_gray_ff <= min_gray_ff) begin
               pix_in   = rd_data_ff;
               state_in = S_OUT;
            end else if (rd_data_ff <= min_gray_ff) begin
               pix_in   = 8'h00;
               state_in = S_OUT;
            end else if (rd_data_ff >= max_gray_ff) begin
               pix_in   = 8'hFF;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = qbit ? 8'(trial - {1'b0, den_ff}) : trial[7:0];
            quo_in = {quo_ff[6:0], qbit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               pix_in   = {quo_ff[6:0], qbit};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pixel_value   = pix_ff;
               rsp_data_in.inside_source = inside_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         addr_ff      <= '0;
         min_gray_ff  <= 8'hFF;
         max_gray_ff  <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         min_gray_ff  <= min_gray_in;
         max_gray_ff  <= max_gray_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      gprod_ff    <= gprod_in;
      pcx_ff      <= pcx_in;
      psy_ff      <= psy_in;
      pcy_ff      <= pcy_in;
      psx_ff      <= psx_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      inside_ff   <= inside_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      pix_ff      <= pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gray_mem[wr_addr] <= gray;
      end
      rd_data_ff <= gray_mem[idx_ff];
   end

   a_out_is_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> cur_ff.is_read)
      else $error("result issued for a load item");

   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |=> min_gray_ff <= max_gray_ff)
      else $error("minimum gray above maximum after a load");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < den_ff)
      else $error("division remainder not below divisor");

endmodule

/* hw/rtl/gray_contrast_rotate_frame_core.sv */
// Grayscale frame store with contrast stretch and nearest-neighbor rotation.
// The req channel carries load items (func 0), one RGB pixel each in raster
// order, and read items (func 1) naming a destination pixel. Loads give no
// result; each read gives one item on the rsp channel with the stretched gray
// value and an inside-source flag. Both channels use valid and stall.
// The csr channel writes the angle and frame sizes; csr_ready is always high,
// and writes are meant for times when no item is in flight.
// The front end classifies an item, registers it and places it in a
// four-entry queue. The back end runs one item at a time: a load passes
// through S_LOAD; a read passes through S_MAP, S_ADDR and S_OUT, with S_MEM
// and S_PREP between when it falls inside the source, and the 8-step
// contrast divider S_DIV after S_PREP unless the frame is flat or the pixel
// clamps. The result register frees the back end from the receiver. While
// rsp_stall is high the result holds; loads keep flowing, but the next read
// waits in S_OUT and holds the back end. The queue fills, then req_stall rises.
// Synchronous reset empties the pipeline, restores the register defaults and
// sets the frame trackers to minimum 255 and maximum 0; the store is not cleared.
module gray_contrast_rotate_frame_core #(
   parameter int MAX_SOURCE_WIDTH  = gcr_pkg::DEF_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = gcr_pkg::DEF_MAX_SOURCE_HEIGHT,
   parameter int ANGLE_FRAC_BITS   = gcr_pkg::DEF_ANGLE_FRAC_BITS,
   parameter int QUEUE_DEPTH       = gcr_pkg::DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import gcr_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_push, q_full, q_pop, q_empty;
   work_type q_wr_data, q_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COS_ANGLE:     cfg_in.cos_angle     = $signed(csr_data);
            CSR_SIN_ANGLE:     cfg_in.sin_angle     = $signed(csr_data);
            CSR_SOURCE_WIDTH:  cfg_in.source_width  = csr_data[8:0];
            CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_data[8:0];
            CSR_DEST_WIDTH:    cfg_in.dest_width    = csr_data[8:0];
            CSR_DEST_HEIGHT:   cfg_in.dest_height   = csr_data[8:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle     <= RST_COS_ANGLE;
         cfg_ff.sin_angle     <= RST_SIN_ANGLE;
         cfg_ff.source_width  <= RST_SIZE;
         cfg_ff.source_height <= RST_SIZE;
         cfg_ff.dest_width    <= RST_SIZE;
         cfg_ff.dest_height   <= RST_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   gcr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   gcr_back #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
      .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/gcr_frame_checker.sv */
`timescale 1ns / 100ps

module gcr_frame_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  gcr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  gcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output int               pending_reads,
   output int               fail_count
);
   import gcr_pkg::*;

   localparam int SRC_W_MAX   = DEF_MAX_SOURCE_WIDTH;
   localparam int SRC_H_MAX   = DEF_MAX_SOURCE_HEIGHT;
   localparam int FRAC_BITS   = DEF_ANGLE_FRAC_BITS;
   localparam int STORE_DEPTH = SRC_W_MAX * SRC_H_MAX;

   logic [7:0] gray_store [STORE_DEPTH];
   int         store_addr;
   int         lo_gray;
   int         hi_gray;
   cfg_type    regs;
   rsp_type    pixel_queue [$];

   initial begin
      pending_reads = 0;
      fail_count    = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int luma_of(input int r, input int g, input int b);
      return (LUMA_R * r + LUMA_G * g + LUMA_B * b) / 1000;
   endfunction

   function automatic longint drop_frac(input longint s);
      if (s < 0)
         return -((-s) >>> FRAC_BITS);
      return s >>> FRAC_BITS;
   endfunction

   task automatic apply_reg(input logic [2:0] index, input logic [15:0] value);
      case (index)
         CSR_COS_ANGLE:     regs.cos_angle     = value;
         CSR_SIN_ANGLE:     regs.sin_angle     = value;
         CSR_SOURCE_WIDTH:  regs.source_width  = value[8:0];
         CSR_SOURCE_HEIGHT: regs.source_height = value[8:0];
         CSR_DEST_WIDTH:    regs.dest_width    = value[8:0];
         CSR_DEST_HEIGHT:   regs.dest_height   = value[8:0];
         default: ;
      endcase
   endtask

   task automatic store_pixel(input req_type item);
      int gray;
      gray = luma_of(item.red, item.green, item.blue);
      if (item.frame_start) begin
         store_addr = 0;
         lo_gray    = 255;
         hi_gray    = 0;
      end
      if (store_addr >= STORE_DEPTH)
         store_addr = 0;
      gray_store[store_addr] = gray[7:0];
      store_addr = (store_addr + 1 >= STORE_DEPTH) ? 0 : store_addr + 1;
      if (gray < lo_gray)
         lo_gray = gray;
      if (gray > hi_gray)
         hi_gray = gray;
   endtask

   function automatic rsp_type predict_read(input req_type item);
      longint  sw, sh, rx, ry, sx, sy, cos_q, sin_q, half;
      int      v, pix;
      rsp_type res;
      sw = regs.source_width;
      sh = regs.source_height;
      if (sw > SRC_W_MAX)
         sw = SRC_W_MAX;
      if (sh > SRC_H_MAX)
         sh = SRC_H_MAX;
      cos_q = $signed(regs.cos_angle);
      sin_q = $signed(regs.sin_angle);
      rx    = item.dest_x;
      half  = regs.dest_width >> 1;
      rx    = rx - half;
      ry    = item.dest_y;
      half  = regs.dest_height >> 1;
      ry    = ry - half;
      sx    = drop_frac(cos_q * rx + sin_q * ry) + sw / 2;
      sy    = drop_frac(cos_q * ry - sin_q * rx) + sh / 2;
      res   = '0;
      if (sx >= 0 && sx < sw && sy >= 0 && sy < sh) begin
         v = gray_store[int'(sy * sw + sx)];
         if (hi_gray <= lo_gray)
            pix = v;
         else if (v <= lo_gray)
            pix = 0;
         else if (v >= hi_gray)
            pix = 255;
         else
            pix = (v - lo_gray) * 255 / (hi_gray - lo_gray);
         res.pixel_value   = pix[7:0];
         res.inside_source = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         store_addr         = 0;
         lo_gray            = 255;
         hi_gray            = 0;
         regs.cos_angle     = RST_COS_ANGLE;
         regs.sin_angle     = RST_SIN_ANGLE;
         regs.source_width  = RST_SIZE;
         regs.source_height = RST_SIZE;
         regs.dest_width    = RST_SIZE;
         regs.dest_height   = RST_SIZE;
         pixel_queue.delete();
      end else begin
         if (csr_valid && csr_ready)
            apply_reg(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            if (req_data.func)
               pixel_queue.push_back(predict_read(req_data));
            else
               store_pixel(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch($sformatf("result value %0d inside %0b with none expected",
                                         rsp_data.pixel_value, rsp_data.inside_source));
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_data.pixel_value !== want.pixel_value)
                  report_mismatch($sformatf("pixel_value got %0d expected %0d",
                                            rsp_data.pixel_value, want.pixel_value));
               if (rsp_data.inside_source !== want.inside_source)
                  report_mismatch($sformatf("inside_source got %0b expected %0b",
                                            rsp_data.inside_source, want.inside_source));
            end
         end
      end
      pending_reads <= pixel_queue.size();
   end

endmodule

/* tb/tb_gray_contrast_rotate_frame_core.sv */
`timescale 1ns / 100ps

module tb_gray_contrast_rotate_frame_core;
   import gcr_pkg::*;

   localparam int SRC_MAX       = DEF_MAX_SOURCE_WIDTH;
   localparam int STORE_DEPTH   = DEF_MAX_SOURCE_WIDTH * DEF_MAX_SOURCE_HEIGHT;
   localparam int DRAIN_CYCLES  = 40;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 350;
   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data  = '0;

   int pending_reads;
   int fail_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;
   int item_count    = 0;
   int load_addr     = 0;
   int written_span  = 0;
   int cur_sw        = 256;
   int cur_sh        = 256;
   int cur_dw        = 256;
   int cur_dh        = 256;

   always #5 clock = ~clock;

   gray_contrast_rotate_frame_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   gcr_frame_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pending_reads (pending_reads),
      .fail_count    (fail_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int clip_size(input int v);
      return (v > SRC_MAX) ? SRC_MAX : v;
   endfunction

   function automatic req_type make_load(input bit fs, input int r, input int g, input int b);
      req_type item;
      item             = '0;
      item.func        = 1'b0;
      item.frame_start = fs;
      item.red         = r[7:0];
      item.green       = g[7:0];
      item.blue        = b[7:0];
      item.dest_x      = 9'($urandom);
      item.dest_y      = 9'($urandom);
      return item;
   endfunction

   function automatic req_type make_read(input bit fs, input int x, input int y);
      req_type item;
      item             = '0;
      item.func        = 1'b1;
      item.frame_start = fs;
      item.red         = 8'($urandom);
      item.green       = 8'($urandom);
      item.blue        = 8'($urandom);
      item.dest_x      = x[8:0];
      item.dest_y      = y[8:0];
      return item;
   endfunction

   function automatic int pick_dest(input int src);
      case ($urandom_range(9))
         0:       return $urandom_range(0, 511);
         1:       return 363;
         2:       return 1;
         default: return src + $urandom_range(0, 6);
      endcase
   endfunction

   function automatic int pick_coord(input int span);
      int lim;
      lim = (span + 1 > 511) ? 511 : span + 1;
      if ($urandom_range(4) == 0)
         return $urandom_range(0, 511);
      return $urandom_range(0, lim);
   endfunction

   task automatic send_item(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (!item.func) begin
         if (item.frame_start)
            load_addr = 0;
         if (load_addr + 1 > written_span)
            written_span = load_addr + 1;
         load_addr = (load_addr + 1 >= STORE_DEPTH) ? 0 : load_addr + 1;
      end
      item_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reads != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input int cos_v, input int sin_v, input int sw, input int sh,
                             input int dw, input int dh, input bit add_unused);
      logic [2:0]  codes [6];
      logic [15:0] vals  [6];
      codes[0] = CSR_COS_ANGLE;
      codes[1] = CSR_SIN_ANGLE;
      codes[2] = CSR_SOURCE_WIDTH;
      codes[3] = CSR_SOURCE_HEIGHT;
      codes[4] = CSR_DEST_WIDTH;
      codes[5] = CSR_DEST_HEIGHT;
      vals[0]  = 16'(cos_v);
      vals[1]  = 16'(sin_v);
      vals[2]  = (16'($urandom) & 16'hFE00) | 16'(sw);
      vals[3]  = (16'($urandom) & 16'hFE00) | 16'(sh);
      vals[4]  = (16'($urandom) & 16'hFE00) | 16'(dw);
      vals[5]  = (16'($urandom) & 16'hFE00) | 16'(dh);
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= codes[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      if (add_unused) begin
         csr_index <= $urandom_range(1) ? CSR_UNUSED_HI : CSR_UNUSED_LO;
         csr_data  <= 16'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cur_sw = sw;
      cur_sh = sh;
      cur_dw = dw;
      cur_dh = dh;
   endtask

   task automatic pick_angle(output int cos_v, output int sin_v);
      int sc, ss;
      sc = $urandom_range(1) ? -1 : 1;
      ss = $urandom_range(1) ? -1 : 1;
      case ($urandom_range(9))
         0: begin cos_v = 16384;  sin_v = 0;      end
         1: begin cos_v = 0;      sin_v = 16384;  end
         2: begin cos_v = -16384; sin_v = 0;      end
         3: begin cos_v = 0;      sin_v = -16384; end
         4: begin cos_v = sc * 11585; sin_v = ss * 11585; end
         5: begin cos_v = sc * 14189; sin_v = ss * 8192;  end
         6: begin cos_v = $urandom_range(0, 65535); sin_v = $urandom_range(0, 65535); end
         default: begin
            cos_v = $urandom_range(0, 32768) - 16384;
            sin_v = $urandom_range(0, 32768) - 16384;
         end
      endcase
   endtask

   task automatic run_session();
      int sw, sh, dw, dh, cos_v, sin_v, area, n_load, n_reads, mode, base, roll;
      int r, g, b;
      wait_drained();
      case ($urandom_range(29))
         0: begin sw = 256; sh = $urandom_range(1, 2); end
         1: begin sw = $urandom_range(1, 2); sh = 256; end
         2: begin sw = $urandom_range(1) ? 511 : $urandom_range(257, 510); sh = 1; end
         3: begin sw = 1; sh = $urandom_range(1) ? 511 : $urandom_range(257, 510); end
         4: begin sw = 0; sh = $urandom_range(0, 16); end
         5: begin sw = $urandom_range(1, 16); sh = 0; end
         default: begin sw = $urandom_range(1, 16); sh = $urandom_range(1, 16); end
      endcase
      dw = pick_dest(clip_size(sw));
      dh = pick_dest(clip_size(sh));
      pick_angle(cos_v, sin_v);
      write_regs(cos_v, sin_v, sw, sh, dw, dh, $urandom_range(3) == 0);
      area   = clip_size(sw) * clip_size(sh);
      n_load = area;
      if (area == 0)
         n_load = $urandom_range(1, 6);
      else if (area <= written_span && $urandom_range(9) < 2)
         n_load = $urandom_range(1, area);
      if (area > written_span || $urandom_range(9) < 7) begin
         mode = $urandom_range(2);
         base = $urandom_range(0, 225);
         r    = $urandom_range(0, 255);
         g    = $urandom_range(0, 255);
         b    = $urandom_range(0, 255);
         for (int i = 0; i < n_load; i++) begin
            if (mode == 0) begin
               r = $urandom_range(0, 255);
               g = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
            end else if (mode == 1) begin
               r = base + $urandom_range(0, 30);
               g = base + $urandom_range(0, 30);
               b = base + $urandom_range(0, 30);
            end
            send_item(make_load(i == 0, r, g, b));
         end
      end
      n_reads = $urandom_range(8, 30);
      for (int i = 0; i < n_reads; i++) begin
         if ($urandom_range(99) < 2)
            wait_drained();
         roll = $urandom_range(99);
         if (roll < 8)
            send_item(make_load(1'b0, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255)));
         else if (roll < 10)
            send_item(make_load(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255)));
         else
            send_item(make_read($urandom_range(3) == 0, pick_coord(cur_dw),
                                pick_coord(cur_dh)));
      end
   endtask

   initial begin
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct <= 82;

      write_regs(16384, 0, 4, 2, 4, 2, 1'b1);
      send_item(make_read(1'b1, 511, 511));
      send_item(make_load(1'b1, 0, 0, 0));
      send_item(make_load(1'b0, 255, 255, 255));
      send_item(make_load(1'b0, 255, 0, 0));
      send_item(make_load(1'b0, 0, 255, 0));
      send_item(make_load(1'b0, 0, 0, 255));
      send_item(make_load(1'b0, 1, 2, 3));
      send_item(make_load(1'b0, 128, 64, 32));
      send_item(make_load(1'b0, 255, 255, 0));
      send_item(make_read(1'b0, 0, 0));
      send_item(make_read(1'b0, 1, 0));
      send_item(make_read(1'b0, 2, 0));
      send_item(make_read(1'b0, 3, 1));
      send_item(make_read(1'b0, 4, 0));
      send_item(make_read(1'b0, 1, 2));
      send_item(make_load(1'b1, 100, 100, 100));
      send_item(make_load(1'b0, 150, 150, 150));
      send_item(make_load(1'b0, 120, 120, 120));
      send_item(make_read(1'b0, 0, 0));
      send_item(make_read(1'b0, 1, 0));
      send_item(make_read(1'b0, 2, 0));
      send_item(make_read(1'b0, 3, 0));
      send_item(make_read(1'b0, 0, 1));
      send_item(make_read(1'b0, 3, 1));
      send_item(make_load(1'b1, 77, 77, 77));
      send_item(make_read(1'b0, 0, 0));
      send_item(make_read(1'b1, 1, 0));

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 29 : (p == 1) ? 82 : 0;
         recv_idle_pct <= (p == 0) ? 82 : (p == 1) ? 29 : 0;
         target = item_count + PHASE_ITEMS;
         while (item_count < target)
            run_session();
      end

      wait_drained();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* gray_contrast_rotate_frame_core.f */
hw/rtl/gcr_pkg.sv
hw/rtl/gcr_front.sv
hw/rtl/gcr_queue.sv
hw/rtl/gcr_back.sv
hw/rtl/gray_contrast_rotate_frame_core.sv
tb/gcr_frame_checker.sv
tb/tb_gray_contrast_rotate_frame_core.sv
